FILE: design/cao_pkg.sv
// shared types, constants and helpers for the cursor alpha overlay
// no dependencies; imported by the top, cao_cfg and cao_blend

package cao_pkg;

  // default cursor edge length in pixels
  localparam int unsigned CURSOR_DIM_DEF = 64;

  // apb register file
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [12:0] SCREEN_W_RST = 13'd800;
  localparam logic [12:0] SCREEN_H_RST = 13'd600;

  localparam logic [7:0]  ALPHA_NONE = 8'h00;
  localparam logic [7:0]  ALPHA_FULL = 8'hFF;

  typedef enum logic [2:0] {
    REG_POS_X    = 3'd0,
    REG_POS_Y    = 3'd1,
    REG_HOT_X    = 3'd2,
    REG_HOT_Y    = 3'd3,
    REG_CURSOR   = 3'd4,
    REG_DISPLAY  = 3'd5,
    REG_SCREEN_W = 3'd6,
    REG_SCREEN_H = 3'd7
  } reg_idx_e;

  // how the output pixel is formed
  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_BG   = 2'd1,
    MODE_FG   = 2'd2,
    MODE_MIX  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [5:0]  hot_x;
    logic [5:0]  hot_y;
    logic        cursor_on;
    logic        display_on;
    logic [12:0] screen_w;
    logic [12:0] screen_h;
  } cao_cfg_t;

  // request state after the image read has been issued
  typedef struct packed {
    logic        func;
    logic        apply;
    logic        fill_ok;
    logic        loaded;
    logic [31:0] bg;
  } cao_s1_t;

  // exact x / 255 for x up to 65279
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

FILE: design/cursor_alpha_overlay_top.sv
// top level of the hardware cursor overlay
// depends on cao_pkg, cao_cfg, cao_ram and cao_blend

// Hardware cursor overlay for ARGB8888 pixel streams. Each input request is
// either an image upload (tuser 0), which writes the next word of the
// CURSOR_DIM x CURSOR_DIM cursor image in row-major order, or a pixel
// (tuser 1), which is composited against the cursor when cursor and display
// are enabled and the pixel lies inside the screen and the cursor window
// (position minus hotspot). One request is taken per clock cycle while the
// output is not held back, and every request gives exactly one result; the
// rate is set by the single image ram, which takes one upload write or one
// pixel read per cycle; a result passes the ram read, the channel multipliers
// and the divide-by-255 stage. The pipeline slips stage by stage, so up to
// three requests are held while the output waits. After reset the
// image reads as all zero with no clearing pass: the upload fill count marks
// which words are written until a full image has gone in. Settings are
// written over apb and should only change while the stream is idle.

module cursor_alpha_overlay_top
  import cao_pkg::*;
#(
  parameter int unsigned CURSOR_DIM = CURSOR_DIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb settings port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // input requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pixel_col[11:0], pixel_row[23:12], background[55:24], upload_word[87:56]
  input  logic [87:0]       s_axis_tdata,
  // func[0]
  input  logic              s_axis_tuser,
  // results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pixel_out[31:0]
  output logic [31:0]       m_axis_tdata,
  // cursor_loaded[0]
  output logic              m_axis_tuser
);

  localparam int unsigned IMG    = CURSOR_DIM * CURSOR_DIM;
  localparam int unsigned ADDR_W = $clog2(IMG);
  localparam int unsigned IDX_W  = $clog2(CURSOR_DIM);

  cao_cfg_t cfg;

  logic [11:0] col, row;
  logic [31:0] bg, word;
  logic        func;

  // pipeline handshake
  logic    acc, en1, en2, en3;
  logic    v1_q, v2_q, v3_q;
  cao_s1_t s1_d, s1_q;

  // upload fill count
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              loaded_q, loaded_d;

  // cursor window test
  logic signed [13:0] dx, dy;
  logic               in_x, in_y, in_screen, on;
  logic [ADDR_W-1:0]  addr;
  logic [31:0]        ram_rdata;

  assign col  = s_axis_tdata[11:0];
  assign row  = s_axis_tdata[23:12];
  assign bg   = s_axis_tdata[55:24];
  assign word = s_axis_tdata[87:56];
  assign func = s_axis_tuser;

  cao_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // each stage moves on when the one after it is empty or moving
  assign en3           = !v3_q || m_axis_tready;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;
  assign acc           = s_axis_tvalid && en1;

  // offset inside the cursor image, negative when left of or above it
  assign dx = signed'({2'b00, col}) + signed'({8'd0, cfg.hot_x}) - signed'({2'b00, cfg.pos_x});
  assign dy = signed'({2'b00, row}) + signed'({8'd0, cfg.hot_y}) - signed'({2'b00, cfg.pos_y});

  assign in_x      = !dx[13] && (dx[12:0] < 13'(CURSOR_DIM));
  assign in_y      = !dy[13] && (dy[12:0] < 13'(CURSOR_DIM));
  assign in_screen = ({1'b0, col} < cfg.screen_w) && ({1'b0, row} < cfg.screen_h);
  assign on        = cfg.cursor_on && cfg.display_on;

  assign addr = ADDR_W'(dy[IDX_W-1:0]) * ADDR_W'(CURSOR_DIM) + ADDR_W'(dx[IDX_W-1:0]);

  // upload position wraps after the last word and sets the sticky flag
  always_comb begin
    pos_d    = pos_q;
    loaded_d = loaded_q;
    if (acc && !func) begin
      if (pos_q == ADDR_W'(IMG - 1)) begin
        pos_d    = '0;
        loaded_d = 1'b1;
      end else begin
        pos_d = pos_q + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    s1_d.func    = func;
    s1_d.apply   = on && in_screen && in_x && in_y;
    s1_d.fill_ok = loaded_q || (addr < pos_q);
    s1_d.loaded  = loaded_d;
    s1_d.bg      = bg;
  end

  cao_ram #(
    .WIDTH (32),
    .DEPTH (IMG)
  ) u_img (
    .clk_i   (clk_i),
    .we_i    (acc && !func),
    .waddr_i (pos_q),
    .wdata_i (word),
    .re_i    (acc && func),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      loaded_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      loaded_q <= loaded_d;
      if (en1) begin
        v1_q <= acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
  end

  cao_blend u_blend (
    .clk_i    (clk_i),
    .en2_i    (en2),
    .en3_i    (en3),
    .s1_i     (s1_q),
    .word_i   (ram_rdata),
    .pixel_o  (m_axis_tdata),
    .loaded_o (m_axis_tuser)
  );

  assign m_axis_tvalid = v3_q;

  // the loaded flag never clears once set
  assert property (@(posedge clk_i) disable iff (!rst_ni) loaded_q |=> loaded_q)
    else $error("cursor loaded flag cleared");

  // the last upload word wraps the position and sets the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !func && pos_q == ADDR_W'(IMG - 1)) |=> (pos_q == '0 && loaded_q))
    else $error("upload position did not wrap");

  // an empty output stage always lets a request in
  assert property (@(posedge clk_i) disable iff (!rst_ni) !v3_q |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // a stalled read stage keeps its request
  assert property (@(posedge clk_i) disable iff (!rst_ni) (v1_q && !en1) |=> v1_q)
    else $error("request lost in read stage");

endmodule

FILE: design/cao_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies

module cao_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/cao_cfg.sv
// apb register file holding the cursor and screen settings
// depends on cao_pkg

module cao_cfg
  import cao_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cao_cfg_t          cfg_o
);

  cao_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_POS_X:    cfg_d.pos_x      = pwdata[11:0];
        REG_POS_Y:    cfg_d.pos_y      = pwdata[11:0];
        REG_HOT_X:    cfg_d.hot_x      = pwdata[5:0];
        REG_HOT_Y:    cfg_d.hot_y      = pwdata[5:0];
        REG_CURSOR:   cfg_d.cursor_on  = pwdata[0];
        REG_DISPLAY:  cfg_d.display_on = pwdata[0];
        REG_SCREEN_W: cfg_d.screen_w   = pwdata[12:0];
        REG_SCREEN_H: cfg_d.screen_h   = pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_X:    prdata = {20'd0, cfg_q.pos_x};
      REG_POS_Y:    prdata = {20'd0, cfg_q.pos_y};
      REG_HOT_X:    prdata = {26'd0, cfg_q.hot_x};
      REG_HOT_Y:    prdata = {26'd0, cfg_q.hot_y};
      REG_CURSOR:   prdata = {31'd0, cfg_q.cursor_on};
      REG_DISPLAY:  prdata = {31'd0, cfg_q.display_on};
      REG_SCREEN_W: prdata = {19'd0, cfg_q.screen_w};
      REG_SCREEN_H: prdata = {19'd0, cfg_q.screen_h};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pos_x: 12'd0, pos_y: 12'd0, hot_x: 6'd0, hot_y: 6'd0,
                 cursor_on: 1'b0, display_on: 1'b0,
                 screen_w: SCREEN_W_RST, screen_h: SCREEN_H_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/cao_blend.sv
// blend pipeline: channel products, then divide by 255 and output select
// depends on cao_pkg

module cao_blend
  import cao_pkg::*;
(
  input  logic        clk_i,
  input  logic        en2_i,
  input  logic        en3_i,
  input  cao_s1_t     s1_i,
  input  logic [31:0] word_i,
  output logic [31:0] pixel_o,
  output logic        loaded_o
);

  logic [31:0] fg;
  logic [7:0]  alpha;
  mode_e       mode_d, mode_q;
  logic [15:0] sum_d [3];
  logic [15:0] sum_q [3];
  logic [31:0] fg_q, bg_q;
  logic        loaded2_q;
  logic [31:0] pix_d, pix_q;
  logic        loaded3_q;

  // never-written entries read as zero
  assign fg    = s1_i.fill_ok ? word_i : 32'd0;
  assign alpha = fg[31:24];

  always_comb begin
    if (!s1_i.func) begin
      mode_d = MODE_ZERO;
    end else if (!s1_i.apply || alpha == ALPHA_NONE) begin
      mode_d = MODE_BG;
    end else if (alpha == ALPHA_FULL) begin
      mode_d = MODE_FG;
    end else begin
      mode_d = MODE_MIX;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = 16'(fg[8*c +: 8]) * 16'(alpha)
               + 16'(s1_i.bg[8*c +: 8]) * 16'(ALPHA_FULL - alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      mode_q    <= mode_d;
      sum_q     <= sum_d;
      fg_q      <= fg;
      bg_q      <= s1_i.bg;
      loaded2_q <= s1_i.loaded;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_ZERO: pix_d = 32'd0;
      MODE_BG:   pix_d = bg_q;
      MODE_FG:   pix_d = fg_q;
      MODE_MIX:  pix_d = {ALPHA_FULL, div255(sum_q[2]), div255(sum_q[1]), div255(sum_q[0])};
      default:   pix_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      pix_q     <= pix_d;
      loaded3_q <= loaded2_q;
    end
  end

  assign pixel_o  = pix_q;
  assign loaded_o = loaded3_q;

endmodule
